FILE: rtl/mcom_pkg.sv
// Shared constants and types for the molecule center-of-mass block.
// Default widths, queue depth and the per-molecule flag record.
// No dependencies.
`default_nettype none

package mcom_pkg;

	localparam int MAX_ATOMS_DEF   = 64;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int MASS_WIDTH_DEF  = 16;
	localparam int JOB_DEPTH       = 2;

	typedef struct packed {
		logic overflow;
		logic origin;
	} mcom_flags_t;

endpackage

`default_nettype wire

FILE: rtl/mcom_front.sv
// Front end: accepts atoms, forms position*mass products and accumulates
// weighted sums, mass and atom count; pushes one job per molecule.
// Depends on mcom_pkg.
`default_nettype none

module mcom_front #(
	parameter int MAX_ATOMS   = 64,
	parameter int COORD_WIDTH = 24,
	parameter int MASS_WIDTH  = 16
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire                                              in_valid,
	output logic                                             in_ready,
	input  wire signed [COORD_WIDTH-1:0]                     pos_x,
	input  wire signed [COORD_WIDTH-1:0]                     pos_y,
	input  wire signed [COORD_WIDTH-1:0]                     pos_z,
	input  wire        [MASS_WIDTH-1:0]                      mass,
	input  wire                                              last_atom,
	input  wire                                              origin_frame,
	output logic                                             job_push,
	input  wire                                              job_full,
	output logic signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_x,
	output logic signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_y,
	output logic signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_z,
	output logic [MASS_WIDTH+$clog2(MAX_ATOMS)-1:0]          job_mass,
	output logic [$clog2(MAX_ATOMS+1)-1:0]                   job_count,
	output mcom_pkg::mcom_flags_t                            job_flags
);
	import mcom_pkg::*;

	localparam int PROD_W = COORD_WIDTH + MASS_WIDTH;
	localparam int SUM_W  = PROD_W + $clog2(MAX_ATOMS);
	localparam int MSUM_W = MASS_WIDTH + $clog2(MAX_ATOMS);
	localparam int CNT_W  = $clog2(MAX_ATOMS + 1);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             ovf_q, org_q, ovf_n, org_n;
	logic             first, add, accept, stall, fire;

	logic signed [PROD_W:0]   px_full, py_full, pz_full;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic [MASS_WIDTH-1:0]    mass_s1;
	logic                     vld_s1, add_s1, last_s1;
	logic [CNT_W-1:0]         cnt_s1;
	mcom_flags_t              flags_s1;

	logic signed [SUM_W-1:0] sx_q, sy_q, sz_q, sx_n, sy_n, sz_n;
	logic signed [SUM_W-1:0] ext_x, ext_y, ext_z;
	logic [MSUM_W-1:0]       ms_q, ms_n;

	assign stall    = vld_s1 & last_s1 & job_full;
	assign in_ready = !stall;
	assign accept   = in_valid & in_ready;
	assign fire     = vld_s1 & !stall;

	assign first = (cnt_q == '0) && !ovf_q;
	assign add   = cnt_q < CNT_W'(MAX_ATOMS);
	assign cnt_n = add ? cnt_q + CNT_W'(1) : cnt_q;
	assign ovf_n = ovf_q | !add;
	assign org_n = first ? origin_frame : org_q;

	assign px_full = pos_x * $signed({1'b0, mass});
	assign py_full = pos_y * $signed({1'b0, mass});
	assign pz_full = pos_z * $signed({1'b0, mass});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			org_q <= 1'b0;
		end else if (accept) begin
			if (last_atom) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				org_q <= 1'b0;
			end else begin
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
				org_q <= org_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= px_full[PROD_W-1:0];
			prod_y_s1 <= py_full[PROD_W-1:0];
			prod_z_s1 <= pz_full[PROD_W-1:0];
			mass_s1   <= mass;
			add_s1    <= add;
			last_s1   <= last_atom;
			cnt_s1    <= cnt_n;
			flags_s1  <= '{overflow: ovf_n, origin: org_n};
		end
	end

	assign ext_x = SUM_W'(prod_x_s1);
	assign ext_y = SUM_W'(prod_y_s1);
	assign ext_z = SUM_W'(prod_z_s1);
	assign sx_n  = add_s1 ? sx_q + ext_x : sx_q;
	assign sy_n  = add_s1 ? sy_q + ext_y : sy_q;
	assign sz_n  = add_s1 ? sz_q + ext_z : sz_q;
	assign ms_n  = add_s1 ? ms_q + MSUM_W'(mass_s1) : ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			ms_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				sx_q <= '0;
				sy_q <= '0;
				sz_q <= '0;
				ms_q <= '0;
			end else begin
				sx_q <= sx_n;
				sy_q <= sy_n;
				sz_q <= sz_n;
				ms_q <= ms_n;
			end
		end
	end

	assign job_push  = fire & last_s1;
	assign job_sum_x = sx_n;
	assign job_sum_y = sy_n;
	assign job_sum_z = sz_n;
	assign job_mass  = ms_n;
	assign job_count = cnt_s1;
	assign job_flags = flags_s1;

endmodule

`default_nettype wire

FILE: rtl/mcom_fifo.sv
// Short job queue between the accumulating front end and the divider.
// Register file with read and write pointers. Depends on mcom_pkg.
`default_nettype none

module mcom_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mcom_pkg::JOB_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] din,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty
);
	import mcom_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push, do_pop;

	assign full      = fill_q == FILL_W'(DEPTH);
	assign not_empty = fill_q != '0;
	assign do_push   = push & !full;
	assign do_pop    = pop & not_empty;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mcom_back.sv
// Back end: restoring divider that forms one quotient bit per cycle for all
// three axes at once, then a registered result stage. Depends on mcom_pkg.
`default_nettype none

module mcom_back #(
	parameter int MAX_ATOMS   = 64,
	parameter int COORD_WIDTH = 24,
	parameter int MASS_WIDTH  = 16
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire                                              job_valid,
	output logic                                             job_pop,
	input  wire signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_x,
	input  wire signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_y,
	input  wire signed [COORD_WIDTH+MASS_WIDTH+$clog2(MAX_ATOMS)-1:0] job_sum_z,
	input  wire        [MASS_WIDTH+$clog2(MAX_ATOMS)-1:0]    job_mass,
	input  wire        [$clog2(MAX_ATOMS+1)-1:0]             job_count,
	input  mcom_pkg::mcom_flags_t                            job_flags,
	output logic                                             out_valid,
	input  wire                                              out_ready,
	output logic signed [COORD_WIDTH-1:0]                    center_x,
	output logic signed [COORD_WIDTH-1:0]                    center_y,
	output logic signed [COORD_WIDTH-1:0]                    center_z,
	output logic [$clog2(MAX_ATOMS+1)-1:0]                   atom_total,
	output logic                                             record_origin,
	output logic                                             zero_mass,
	output logic                                             atom_overflow
);
	import mcom_pkg::*;

	localparam int SUM_W  = COORD_WIDTH + MASS_WIDTH + $clog2(MAX_ATOMS);
	localparam int MSUM_W = MASS_WIDTH + $clog2(MAX_ATOMS);
	localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
	localparam int STEP_W = $clog2(COORD_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [MSUM_W-1:0] den_q;
	logic              zero_q;
	logic [CNT_W-1:0]  cnt_q;
	mcom_flags_t       flags_q;

	logic [MSUM_W-1:0]      rem_q [3];
	logic [COORD_WIDTH-1:0] sh_q  [3];
	logic                   neg_q [3];
	logic [MSUM_W-1:0]      rem_n [3];
	logic [COORD_WIDTH-1:0] sh_n  [3];
	logic [COORD_WIDTH-1:0] quo   [3];
	logic [SUM_W-1:0]       sum_in [3];
	logic [SUM_W-1:0]       mag [3];
	logic                   out_free;
	logic                   out_load;

	assign sum_in[0] = job_sum_x;
	assign sum_in[1] = job_sum_y;
	assign sum_in[2] = job_sum_z;

	assign job_pop  = (state_q == ST_IDLE) & job_valid;
	assign out_free = !out_valid | out_ready;
	assign out_load = (state_q == ST_DONE) & out_free;

	always_comb begin
		logic [MSUM_W:0] r2;
		logic            ge;
		for (int i = 0; i < 3; i++) begin
			mag[i] = sum_in[i][SUM_W-1] ? (SUM_W'(0) - sum_in[i]) : sum_in[i];
			r2 = {rem_q[i], sh_q[i][COORD_WIDTH-1]};
			ge = r2 >= {1'b0, den_q};
			rem_n[i] = ge ? MSUM_W'(r2 - {1'b0, den_q}) : r2[MSUM_W-1:0];
			sh_n[i]  = {sh_q[i][COORD_WIDTH-2:0], ge};
			quo[i]   = zero_q ? '0 : (neg_q[i] ? (COORD_WIDTH'(0) - sh_q[i]) : sh_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			out_valid     <= 1'b0;
			center_x      <= '0;
			center_y      <= '0;
			center_z      <= '0;
			atom_total    <= '0;
			record_origin <= 1'b0;
			zero_mass     <= 1'b0;
			atom_overflow <= 1'b0;
		end else begin
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(COORD_WIDTH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						center_x      <= quo[0];
						center_y      <= quo[1];
						center_z      <= quo[2];
						atom_total    <= cnt_q;
						record_origin <= flags_q.origin;
						zero_mass     <= zero_q;
						atom_overflow <= flags_q.overflow;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			den_q   <= job_mass;
			zero_q  <= job_mass == '0;
			cnt_q   <= job_count;
			flags_q <= job_flags;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= sum_in[i][SUM_W-1];
				rem_q[i] <= mag[i][SUM_W-1:COORD_WIDTH];
				sh_q[i]  <= mag[i][COORD_WIDTH-1:0];
			end
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_n[i];
				sh_q[i]  <= sh_n[i];
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/molecule_center_of_mass_top.sv
// Path to center valid: product register, job queue, divider states ST_IDLE,
// ST_RUN and ST_DONE, result register. Throughput: one atom per cycle unless a
// last atom waits on a full queue; one quotient bit per cycle, jobs only in ST_IDLE.
// A two-entry job queue lets atoms stream while a molecule is divided.
// Reset: arst_n clears all accumulators, the queue and the result valid.
// Top level of the molecule center-of-mass block; uses mcom_pkg and submodules.
`default_nettype none

module molecule_center_of_mass_top #(
	parameter int MAX_ATOMS   = mcom_pkg::MAX_ATOMS_DEF,
	parameter int COORD_WIDTH = mcom_pkg::COORD_WIDTH_DEF,
	parameter int MASS_WIDTH  = mcom_pkg::MASS_WIDTH_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z, mass, zero fill
	input  wire  [((3*COORD_WIDTH+MASS_WIDTH+7)/8)*8-1:0] s_tdata,
	input  wire  s_tlast,
	// origin_frame
	input  wire  s_tuser,
	output logic m_tvalid,
	input  wire  m_tready,
	// center_x, center_y, center_z, atom_total, zero fill
	output logic [((3*COORD_WIDTH+$clog2(MAX_ATOMS+1)+7)/8)*8-1:0] m_tdata,
	// record_origin, zero_mass, atom_overflow
	output logic [2:0] m_tuser
);
	import mcom_pkg::*;

	localparam int SUM_W   = COORD_WIDTH + MASS_WIDTH + $clog2(MAX_ATOMS);
	localparam int MSUM_W  = MASS_WIDTH + $clog2(MAX_ATOMS);
	localparam int CNT_W   = $clog2(MAX_ATOMS + 1);
	localparam int FLAG_W  = $bits(mcom_flags_t);
	localparam int JOB_W   = 3 * SUM_W + MSUM_W + CNT_W + FLAG_W;
	localparam int OUT_W   = 3 * COORD_WIDTH + CNT_W;
	localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

	logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z;
	logic [MASS_WIDTH-1:0]         mass;

	logic                    push, full, pop, not_empty;
	logic signed [SUM_W-1:0] f_sx, f_sy, f_sz, b_sx, b_sy, b_sz;
	logic [MSUM_W-1:0]       f_ms, b_ms;
	logic [CNT_W-1:0]        f_cnt, b_cnt;
	mcom_flags_t             f_flags, b_flags;
	logic [JOB_W-1:0]        job_in, job_out;

	logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;
	logic [CNT_W-1:0]              atom_total;
	logic                          record_origin, zero_mass, atom_overflow;

	assign pos_x = s_tdata[COORD_WIDTH-1:0];
	assign pos_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign pos_z = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign mass  = s_tdata[3*COORD_WIDTH+MASS_WIDTH-1:3*COORD_WIDTH];

	mcom_front #(
		.MAX_ATOMS   (MAX_ATOMS),
		.COORD_WIDTH (COORD_WIDTH),
		.MASS_WIDTH  (MASS_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.mass         (mass),
		.last_atom    (s_tlast),
		.origin_frame (s_tuser),
		.job_push     (push),
		.job_full     (full),
		.job_sum_x    (f_sx),
		.job_sum_y    (f_sy),
		.job_sum_z    (f_sz),
		.job_mass     (f_ms),
		.job_count    (f_cnt),
		.job_flags    (f_flags)
	);

	assign job_in = {f_flags, f_cnt, f_ms, f_sz, f_sy, f_sx};

	mcom_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (job_in),
		.full      (full),
		.pop       (pop),
		.dout      (job_out),
		.not_empty (not_empty)
	);

	assign {b_flags, b_cnt, b_ms, b_sz, b_sy, b_sx} = job_out;

	mcom_back #(
		.MAX_ATOMS   (MAX_ATOMS),
		.COORD_WIDTH (COORD_WIDTH),
		.MASS_WIDTH  (MASS_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (not_empty),
		.job_pop       (pop),
		.job_sum_x     (b_sx),
		.job_sum_y     (b_sy),
		.job_sum_z     (b_sz),
		.job_mass      (b_ms),
		.job_count     (b_cnt),
		.job_flags     (b_flags),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.atom_total    (atom_total),
		.record_origin (record_origin),
		.zero_mass     (zero_mass),
		.atom_overflow (atom_overflow)
	);

	assign m_tdata = OUT_TW'({atom_total, center_z, center_y, center_x});
	assign m_tuser = {atom_overflow, zero_mass, record_origin};

endmodule

`default_nettype wire
